// ----- sv/bsc_pkg.sv -----
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and codes of the banker's safety checker: status codes,
// function codes and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int FIELD_W      = 8;
    localparam int SLOT_FIELD_W = 4;
    localparam int STATUS_W     = 3;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_WRITTEN    = 3'd0;
    localparam status_t ST_SAFE       = 3'd1;
    localparam status_t ST_UNSAFE     = 3'd2;
    localparam status_t ST_OVER_AVAIL = 3'd3;
    localparam status_t ST_OVER_NEED  = 3'd4;
    localparam status_t ST_INACTIVE   = 3'd5;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    typedef struct packed {
        logic accept;
        logic write;
        logic setup;
        logic step;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic err;
        logic any_cand;
    } dp_sts_t;

endpackage

// ----- sv/bsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsc_ctrl
// Controller of the safety checker: sequences accept, slot write, check
// setup, safety search and result delivery, and owns the in and out handshakes.
// ----------------------------------------------------------------------------
module bsc_ctrl
    import bsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    func,
    output logic    out_valid,
    input  logic    out_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_WRITE  = 5'b00010,
        S_SETUP  = 5'b00100,
        S_SEARCH = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (func == FUNC_CHECK) ? S_SETUP : S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_FINISH;
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = sts.err ? S_FINISH : S_SEARCH;
            end
            S_SEARCH:
            begin
                // one finishing slot per cycle until none fits the pool
                cmd.step = 1'b1;
                if (!sts.any_cand)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- sv/bsc_datapath.sv -----
// ----------------------------------------------------------------------------
// bsc_datapath
// Job slot table, running allocation sum, request checks and the safety
// search pool with its parallel slot compare and lowest-slot pick.
// ----------------------------------------------------------------------------
module bsc_datapath
    import bsc_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [FIELD_W-1:0]      cfg_data,
    input  logic                    func,
    input  logic [SLOT_FIELD_W-1:0] slot,
    input  logic                    active,
    input  logic [FIELD_W-1:0]      max_claim,
    input  logic [FIELD_W-1:0]      allocated,
    input  logic [FIELD_W-1:0]      request,
    input  dp_cmd_t                 cmd,
    output dp_sts_t                 sts,
    output logic [STATUS_W-1:0]     status,
    output logic [FIELD_W-1:0]      available_now
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int SUM_W  = COUNT_BITS + SLOT_W;
    localparam int CMP_W  = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;
    localparam int AV_W   = (SUM_W > FIELD_W) ? SUM_W : FIELD_W;
    localparam int WORK_W = CMP_W + SLOT_W + 1;

    // slot table
    logic [SLOTS-1:0]      act_reg;
    logic [COUNT_BITS-1:0] max_reg   [SLOTS];
    logic [COUNT_BITS-1:0] alloc_reg [SLOTS];
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum_next;
    logic [FIELD_W-1:0]    total_reg;

    // latched item
    logic                    func_reg;
    logic [SLOT_FIELD_W-1:0] slot_reg;
    logic                    act_in_reg;
    logic [FIELD_W-1:0]      max_in_reg;
    logic [FIELD_W-1:0]      alloc_in_reg;
    logic [FIELD_W-1:0]      req_reg;

    // search state
    logic [SLOTS-1:0]      done_reg;
    logic [SLOTS-1:0]      req_oh_reg;
    logic [WORK_W-1:0]     work_reg;
    logic [COUNT_BITS-1:0] req_need_reg;
    logic [COUNT_BITS-1:0] req_alloc_reg;
    status_t               status_reg;
    status_t               out_status_reg;
    logic [FIELD_W-1:0]    out_avail_reg;

    logic                  range_ok;
    logic [SLOT_W-1:0]     ridx;
    logic                  r_act;
    logic [COUNT_BITS-1:0] r_max;
    logic [COUNT_BITS-1:0] r_alloc;
    logic [COUNT_BITS-1:0] r_need;
    logic [COUNT_BITS-1:0] old_contrib;
    logic [COUNT_BITS-1:0] new_contrib;
    logic [FIELD_W-1:0]    avail_c;
    status_t               err_code;
    logic                  err;

    logic [SLOTS-1:0]      cand;
    logic [SLOTS-1:0]      pick;
    logic [COUNT_BITS-1:0] alloc_pick;

    assign range_ok = (32'(slot_reg) < SLOTS);
    assign ridx     = SLOT_W'(slot_reg);
    assign r_act    = range_ok && act_reg[ridx];
    assign r_max    = max_reg[ridx];
    assign r_alloc  = alloc_reg[ridx];
    assign r_need   = (r_max > r_alloc) ? (r_max - r_alloc) : '0;

    // incremental sum of active allocations
    assign old_contrib = r_act ? r_alloc : '0;
    assign new_contrib = act_in_reg ? COUNT_BITS'(alloc_in_reg) : '0;
    assign sum_next    = sum_reg - SUM_W'(old_contrib) + SUM_W'(new_contrib);

    assign avail_c = (AV_W'(sum_reg) >= AV_W'(total_reg)) ? '0
                   : FIELD_W'(AV_W'(total_reg) - AV_W'(sum_reg));

    always_comb
    begin
        err      = 1'b1;
        err_code = ST_INACTIVE;
        if (!r_act)
        begin
            err_code = ST_INACTIVE;
        end
        else if (CMP_W'(req_reg) > CMP_W'(r_need))
        begin
            err_code = ST_OVER_NEED;
        end
        else if (req_reg > avail_c)
        begin
            err_code = ST_OVER_AVAIL;
        end
        else
        begin
            err = 1'b0;
        end
    end

    // every slot against the pool, requester carries the pretended grant
    always_comb
    begin
        logic [COUNT_BITS-1:0] need_i;
        logic [COUNT_BITS-1:0] need_e;
        logic [COUNT_BITS-1:0] alloc_e;
        alloc_pick = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            need_i  = (max_reg[i] > alloc_reg[i]) ? (max_reg[i] - alloc_reg[i]) : '0;
            need_e  = req_oh_reg[i] ? req_need_reg : need_i;
            cand[i] = !done_reg[i] && (WORK_W'(need_e) <= work_reg);
        end
        pick = cand & (~cand + SLOTS'(1));
        for (int i = 0; i < SLOTS; i++)
        begin
            alloc_e = req_oh_reg[i] ? req_alloc_reg : alloc_reg[i];
            if (pick[i])
            begin
                alloc_pick = alloc_pick | alloc_e;
            end
        end
    end

    assign sts.err      = err;
    assign sts.any_cand = |cand;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= '0;
            sum_reg   <= '0;
            total_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                max_reg[i]   <= '0;
                alloc_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                total_reg <= cfg_data;
            end
            if (cmd.write && range_ok)
            begin
                act_reg[ridx]   <= act_in_reg;
                max_reg[ridx]   <= COUNT_BITS'(max_in_reg);
                alloc_reg[ridx] <= COUNT_BITS'(alloc_in_reg);
                sum_reg         <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg     <= func;
            slot_reg     <= slot;
            act_in_reg   <= active;
            max_in_reg   <= max_claim;
            alloc_in_reg <= allocated;
            req_reg      <= request;
        end
        if (cmd.write)
        begin
            status_reg <= ST_WRITTEN;
        end
        if (cmd.setup)
        begin
            status_reg    <= err_code;
            done_reg      <= ~act_reg;
            req_need_reg  <= r_need - COUNT_BITS'(req_reg);
            req_alloc_reg <= r_alloc + COUNT_BITS'(req_reg);
            work_reg      <= WORK_W'(avail_c - req_reg);
            for (int i = 0; i < SLOTS; i++)
            begin
                req_oh_reg[i] <= (i == 32'(ridx));
            end
        end
        if (cmd.step)
        begin
            if (|cand)
            begin
                done_reg <= done_reg | pick;
                work_reg <= work_reg + WORK_W'(alloc_pick);
            end
            else
            begin
                status_reg <= (&done_reg) ? ST_SAFE : ST_UNSAFE;
            end
        end
        if (cmd.emit)
        begin
            out_status_reg <= (func_reg == FUNC_CHECK) ? status_reg : ST_WRITTEN;
            out_avail_reg  <= avail_c;
        end
    end

    assign status        = out_status_reg;
    assign available_now = out_avail_reg;

endmodule

// ----- sv/bankers_safety_check_top.sv -----
// ----------------------------------------------------------------------------
// bankers_safety_check_top
// Banker's algorithm safety checker for one resource type over a table of
// job slots: slot writes, request checks with error codes and a safety verdict.
// ----------------------------------------------------------------------------
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  cfg     | cfg_valid cfg_ready cfg_data (total devices)     | in
//  in      | in_valid in_ready func slot active max_claim     | in
//          | allocated request                                |
//  out     | out_valid out_ready status available_now         | out
//
//  a slot write passes the write and finish steps from accept to result, a check
//  passes setup and finish when it ends in an error and setup, search and finish otherwise
//  the check time is set by the safety search, which retires one finishing
//  slot per cycle after a parallel compare of all slots against the pool
//  reset clears the slot table and total devices at once, no clearing pass
//  a new request is taken while the previous result waits at the output;
//  a stalled output holds the block in its last step until it drains
module bankers_safety_check_top
    import bsc_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [FIELD_W-1:0]      cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    func,
    input  logic [SLOT_FIELD_W-1:0] slot,
    input  logic                    active,
    input  logic [FIELD_W-1:0]      max_claim,
    input  logic [FIELD_W-1:0]      allocated,
    input  logic [FIELD_W-1:0]      request,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [STATUS_W-1:0]     status,
    output logic [FIELD_W-1:0]      available_now
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    bsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bsc_datapath #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .func          (func),
        .slot          (slot),
        .active        (active),
        .max_claim     (max_claim),
        .allocated     (allocated),
        .request       (request),
        .cmd           (cmd),
        .sts           (sts),
        .status        (status),
        .available_now (available_now)
    );

endmodule

// ----- sv/bsc_checker.sv -----
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level assertions for the safety checker, bound to the top level.
// ----------------------------------------------------------------------------
module bsc_checker
    import bsc_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    func,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [STATUS_W-1:0]     status,
    input logic [FIELD_W-1:0]      available_now
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)
                                       && $stable(available_now)))
        else $error("stalled result changed");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("block ready right after taking a request");

    // a slot write answers written after its write and finish steps when the output is free
    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (func == FUNC_WRITE) && !out_valid)
        |=> ##2 (out_valid && (status == ST_WRITTEN)))
        else $error("slot write result missing or wrong");

    // a check never answers before its setup step
    a_check_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (func == FUNC_CHECK) && !out_valid)
        |=> !out_valid ##1 !out_valid)
        else $error("check result too early");

endmodule

bind bankers_safety_check_top bsc_checker u_bsc_checker (.*);
